// File: design/tbhc_pkg.sv
package tbhc_pkg;

    // number of bands in use, clamped to at least 2 and at most the defined table
    localparam int BAND_COUNT  = 7;
    localparam int TABLE_BANDS = 7;
    localparam int NBANDS      = (BAND_COUNT > TABLE_BANDS) ? TABLE_BANDS :
                                 ((BAND_COUNT < 2) ? 2 : BAND_COUNT);

    typedef logic signed [11:0] t_temp;
    typedef logic [2:0]         t_band;
    typedef logic [7:0]         t_deadband;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam t_band TOP_BAND = t_band'(NBANDS - 1);

    // heat and cool thresholds in tenths of a degree
    localparam t_temp HEAT_TENTHS [TABLE_BANDS] = '{
        12'sd0, 12'sd350, 12'sd620, 12'sd710, 12'sd770, 12'sd820, 12'sd860
    };
    localparam t_temp COOL_TENTHS [TABLE_BANDS] = '{
        -12'sd500, 12'sd250, 12'sd550, 12'sd680, 12'sd740, 12'sd790, 12'sd840
    };

    // fixed colour of each band
    function automatic t_rgb band_colour(input t_band b);
        t_rgb c;
        case (b)
            3'd0:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
            3'd1:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            3'd2:    c = '{red: 8'd100, green: 8'd200, blue: 8'd255};
            3'd3:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
            3'd4:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            3'd5:    c = '{red: 8'd255, green: 8'd210, blue: 8'd0};
            default: c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
        endcase
        return c;
    endfunction

endpackage

// File: design/temperature_band_hysteresis_classifier.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------------
// sample   | in        | i_valid / o_stall    | i_temperature_tenths
// result   | out       | o_valid / i_stall    | o_band_index, o_red/green/blue,
//          |           |                      | o_rising, o_accepted
// config   | in        | i_cfg_we             | i_cfg_wdata (dead-band, tenths)
//
// one word per cycle while the result side does not stall; an accepted sample passes
// through the input register, then the band decision into the result register
// band state is updated as a word moves into the result register, so each word sees
// the state left by the one before it
// reset is synchronous, active low: dead-band 1, band 0, falling, last sample 0
// a stall on the result side holds the result register and then the input register
module temperature_band_hysteresis_classifier (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  tbhc_pkg::t_deadband    i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  tbhc_pkg::t_temp        i_temperature_tenths,
    output logic                   o_valid,
    input  logic                   i_stall,
    output tbhc_pkg::t_band        o_band_index,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue,
    output logic                   o_rising,
    output logic                   o_accepted
);
    import tbhc_pkg::*;

    t_deadband r_deadband;
    logic      r_in_vld;
    t_temp     r_in_temp;
    logic      r_out_vld;
    t_temp     r_last_temp;
    t_band     r_band;
    logic      r_rising;
    logic      r_accepted;
    t_rgb      r_rgb;

    logic               advance;
    logic signed [12:0] diff;
    logic [12:0]        mag;
    logic               acc;
    logic               n_rising;
    t_band              heat_cnt;
    t_band              cool_cnt;
    t_band              moved_band;
    t_band              n_band;

    // flow control between the two registers
    assign advance = !r_out_vld || !i_stall;
    assign o_stall = r_in_vld && !advance;

    // dead-band test against the last accepted sample
    always_comb begin
        diff     = 13'(r_in_temp) - 13'(r_last_temp);
        mag      = diff[12] ? 13'(-diff) : 13'(diff);
        acc      = mag > 13'(r_deadband);
        n_rising = acc ? (r_in_temp > r_last_temp) : r_rising;
    end

    // thresholds passed by the sample, counted above band 0
    always_comb begin
        heat_cnt = '0;
        cool_cnt = '0;
        for (int k = 1; k < NBANDS; k++) begin
            if (r_in_temp >= HEAT_TENTHS[k]) begin
                heat_cnt = heat_cnt + 3'd1;
            end
            if (r_in_temp > COOL_TENTHS[k]) begin
                cool_cnt = cool_cnt + 3'd1;
            end
        end
    end

    // band: 0 below zero, top at top heat, else climb to heat or drop to cool count
    always_comb begin
        if (r_in_temp < 0) begin
            moved_band = '0;
        end else if (r_in_temp >= HEAT_TENTHS[NBANDS - 1]) begin
            moved_band = TOP_BAND;
        end else if (n_rising) begin
            moved_band = (heat_cnt > r_band) ? heat_cnt : r_band;
        end else begin
            moved_band = (cool_cnt < r_band) ? cool_cnt : r_band;
        end
        n_band = acc ? moved_band : r_band;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= 8'd1;
        end else if (i_cfg_we) begin
            r_deadband <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_temp <= i_temperature_tenths;
        end
    end

    // band state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_last_temp <= '0;
            r_band      <= '0;
            r_rising    <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_band   <= n_band;
                r_rising <= n_rising;
                if (acc) begin
                    r_last_temp <= r_in_temp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_accepted <= acc;
            r_rgb      <= band_colour(n_band);
        end
    end

    assign o_valid      = r_out_vld;
    assign o_band_index = r_band;
    assign o_red        = r_rgb.red;
    assign o_green      = r_rgb.green;
    assign o_blue       = r_rgb.blue;
    assign o_rising     = r_rising;
    assign o_accepted   = r_accepted;

endmodule
